// File: hw/rtl/rhpm_pkg.sv
// Shared constants, types and sequencer states of the rolling hash pattern matcher.
// Used by the channel interfaces, the modular reducer and the top level.
`timescale 1ns / 1ps

package rhpm_pkg;

  // Storage sizes of the pattern and of the text window.
  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  // Field widths.
  localparam int CHAR_W     = 8;
  localparam int WORD_W     = 32;
  localparam int BASE_W     = 16;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // The reducer sees at most a word times the base plus a byte.
  localparam int PROD_W = WORD_W + BASE_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(1);
  localparam logic [WORD_W-1:0]    PRIME_RST = 32'd1000000007;
  localparam logic [BASE_W-1:0]    BASE_RST  = 16'd4;

  // Item operation codes.
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Significant width of the product handed to the reducer.
  typedef enum logic [1:0] {
    MR_W32 = 2'd0,
    MR_W40 = 2'd1,
    MR_W48 = 2'd2
  } mr_width_t;

  // Request to the reducer: result = (a * b + c) mod modulus.
  typedef struct packed {
    logic              go;
    mr_width_t         width;
    logic [WORD_W-1:0] a;
    logic [BASE_W-1:0] b;
    logic [CHAR_W-1:0] c;
  } mr_req_t;

  // Reply of the reducer.
  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } mr_rsp_t;

  // Sequencer states of the top level.
  typedef enum logic [17:0] {
    ST_IDLE     = 18'b000000000000000001,
    ST_PPOW     = 18'b000000000000000010,
    ST_PPOW_W   = 18'b000000000000000100,
    ST_PHASH    = 18'b000000000000001000,
    ST_PHASH_W  = 18'b000000000000010000,
    ST_TFILL    = 18'b000000000000100000,
    ST_TFILL_W  = 18'b000000000001000000,
    ST_TLEAD    = 18'b000000000010000000,
    ST_TLEAD_GO = 18'b000000000100000000,
    ST_TLEAD_W  = 18'b000000001000000000,
    ST_TRTH     = 18'b000000010000000000,
    ST_TRTH_W   = 18'b000000100000000000,
    ST_TMAC     = 18'b000001000000000000,
    ST_TMAC_W   = 18'b000010000000000000,
    ST_RPH      = 18'b000100000000000000,
    ST_RPH_W    = 18'b001000000000000000,
    ST_CMP      = 18'b010000000000000000,
    ST_DONE     = 18'b100000000000000000
  } state_t;

endpackage

// File: hw/rtl/rhpm_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on rhpm_pkg for the field widths.
`timescale 1ns / 1ps

interface rhpm_in_if;
  import rhpm_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_value;
  logic              restart;

  modport source (output valid, output op, output char_value, output restart, input ready);
  modport sink   (input valid, input op, input char_value, input restart, output ready);
endinterface

interface rhpm_out_if;
  import rhpm_pkg::*;

  logic             valid;
  logic             ready;
  logic             match;
  logic [POS_W-1:0] match_start;
  logic             window_full;

  modport source (output valid, output match, output match_start, output window_full,
                  input ready);
  modport sink   (input valid, input match, input match_start, input window_full,
                  output ready);
endinterface

// File: hw/rtl/rhpm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rhpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: hw/rtl/rhpm_mulred.sv
// Multiply-add followed by a bit-serial modular reduction, one bit per cycle.
// Depends on rhpm_pkg for widths and the request and reply structs.
`timescale 1ns / 1ps

module rhpm_mulred (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rhpm_pkg::mr_req_t             req,
  input  logic [rhpm_pkg::WORD_W-1:0]   modulus,
  output rhpm_pkg::mr_rsp_t             rsp
);
  import rhpm_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] x_aligned;
  logic [CNT_W-1:0]  cnt_load;
  logic [PROD_W-1:0] x_r;
  logic [WORD_W-1:0] r_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   step;

  // Exact product plus addend, left-aligned so the top bit shifts out first.
  always_comb begin
    prod = PROD_W'(req.a) * PROD_W'(req.b) + PROD_W'(req.c);
    case (req.width)
      MR_W48: begin
        x_aligned = prod;
        cnt_load  = CNT_W'(PROD_W);
      end
      MR_W40: begin
        x_aligned = prod << (PROD_W - WORD_W - CHAR_W);
        cnt_load  = CNT_W'(WORD_W + CHAR_W);
      end
      MR_W32: begin
        x_aligned = prod << BASE_W;
        cnt_load  = CNT_W'(WORD_W);
      end
      default: begin
        x_aligned = prod;
        cnt_load  = CNT_W'(PROD_W);
      end
    endcase
  end

  // One restoring step: shift in the next bit, subtract the modulus if it fits.
  // A zero modulus means plain 32-bit wrap, so no subtraction is done.
  always_comb begin
    trial = {r_r, x_r[PROD_W-1]};
    if ((modulus != '0) && (trial >= {1'b0, modulus})) begin
      step = trial - {1'b0, modulus};
    end else begin
      step = trial;
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= cnt_load;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand shift register and partial remainder.
  always_ff @(posedge clk) begin
    if (req.go) begin
      x_r <= x_aligned;
      r_r <= '0;
    end else if (busy_r) begin
      x_r <= x_r << 1;
      r_r <= step[WORD_W-1:0];
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = r_r;

endmodule

// File: hw/rtl/rolling_hash_pattern_matcher_unit.sv
// Streaming Rabin-Karp matcher: pattern and window stores, hash sequencer, result register.
// Depends on rhpm_pkg, rhpm_if, rhpm_ram and rhpm_mulred.
// A pattern byte updates the leading power and the pattern hash; a full store drops it.
// A text byte adds to the text hash; with the window full it first drops the oldest byte.
// Equal hashes, from fill-up on, are confirmed byte by byte; no pattern gives no match.
// One item at a time, the next after the result is registered; rst_n (sync) resets control.
`timescale 1ns / 1ps

module rolling_hash_pattern_matcher_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  rhpm_in_if.sink                           in_ch,
  rhpm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rhpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rhpm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rhpm_pkg::*;

  // Configuration registers.
  logic [WORD_W-1:0] prime_r;
  logic [BASE_W-1:0] base_r;

  // Sequencer and architectural state.
  state_t            state_r;
  logic [LEN_W-1:0]  plen_r;
  logic [WORD_W-1:0] ph_r;
  logic [WORD_W-1:0] pow_r;
  logic [LEN_W-1:0]  fill_r;
  logic [WORD_W-1:0] th_r;
  logic [IDX_W-1:0]  head_r;
  logic [POS_W-1:0]  tpos_r;

  // Per-item working registers.
  logic [CHAR_W-1:0] char_r;
  logic [POS_W-1:0]  pos_r;
  logic [WORD_W-1:0] lead_r;
  logic [LEN_W-1:0]  idx_r;
  logic              chk_r;
  logic              mism_r;
  logic              res_hit_r;
  logic              res_full_r;

  // Output register.
  logic              out_valid_r;
  logic              out_match_r;
  logic [POS_W-1:0]  out_start_r;
  logic              out_full_r;

  logic              in_accept;
  logic              out_free;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  eff_fill;
  logic [POS_W-1:0]  eff_tpos;
  logic [WORD_W:0]   diff;
  logic [WORD_W-1:0] sub_res;
  logic [IDX_W-1:0]  head_inc;
  logic [LEN_W:0]    cmp_sum;
  logic [IDX_W-1:0]  cmp_addr;

  mr_req_t           mr_req;
  mr_rsp_t           mr_rsp;

  logic              pat_we;
  logic [IDX_W-1:0]  pat_raddr;
  logic [CHAR_W-1:0] pat_rd;
  logic              win_we;
  logic [IDX_W-1:0]  win_waddr;
  logic [IDX_W-1:0]  win_raddr;
  logic [CHAR_W-1:0] win_rd;

  // Handshakes.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match       = out_match_r;
  assign out_ch.match_start = out_start_r;
  assign out_ch.window_full = out_full_r;

  // State as seen after a restart of the accepted item.
  assign eff_len  = in_ch.restart ? '0 : plen_r;
  assign eff_fill = in_ch.restart ? '0 : fill_r;
  assign eff_tpos = in_ch.restart ? '0 : tpos_r;

  // Modular subtraction of the leading term from the freshly reduced text hash.
  always_comb begin
    diff = {1'b0, mr_rsp.result} - {1'b0, lead_r};
    if (diff[WORD_W] && (prime_r != '0)) begin
      sub_res = diff[WORD_W-1:0] + prime_r;
    end else begin
      sub_res = diff[WORD_W-1:0];
    end
  end

  // Circular window addressing: oldest byte at head, wrap at the pattern length.
  assign head_inc = ((LEN_W'(head_r) + LEN_W'(1)) == plen_r) ? '0 : head_r + IDX_W'(1);

  always_comb begin
    cmp_sum = (LEN_W + 1)'(head_r) + (LEN_W + 1)'(idx_r);
    if (cmp_sum >= (LEN_W + 1)'(plen_r)) begin
      cmp_sum = cmp_sum - (LEN_W + 1)'(plen_r);
    end
    cmp_addr = cmp_sum[IDX_W-1:0];
  end

  // Requests to the shared reducer.
  always_comb begin
    mr_req       = '0;
    mr_req.width = MR_W48;
    case (state_r)
      ST_PPOW: begin
        mr_req.go = (plen_r != '0);
        mr_req.a  = pow_r;
        mr_req.b  = base_r;
      end
      ST_PHASH: begin
        mr_req.go = 1'b1;
        mr_req.a  = ph_r;
        mr_req.b  = base_r;
        mr_req.c  = char_r;
      end
      ST_TFILL: begin
        mr_req.go = 1'b1;
        mr_req.a  = th_r;
        mr_req.b  = base_r;
        mr_req.c  = char_r;
      end
      ST_TLEAD_GO: begin
        mr_req.go    = 1'b1;
        mr_req.width = MR_W40;
        mr_req.a     = pow_r;
        mr_req.b     = BASE_W'(win_rd);
      end
      ST_TRTH: begin
        mr_req.go    = 1'b1;
        mr_req.width = MR_W32;
        mr_req.a     = th_r;
        mr_req.b     = BASE_W'(1);
      end
      ST_TMAC: begin
        mr_req.go = 1'b1;
        mr_req.a  = th_r;
        mr_req.b  = base_r;
        mr_req.c  = char_r;
      end
      ST_RPH: begin
        mr_req.go    = 1'b1;
        mr_req.width = MR_W32;
        mr_req.a     = ph_r;
        mr_req.b     = BASE_W'(1);
      end
      default: begin
        mr_req.go = 1'b0;
      end
    endcase
  end

  rhpm_mulred u_mulred (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mr_req),
    .modulus (prime_r),
    .rsp     (mr_rsp)
  );

  // Pattern store: written while loading, read in order during confirmation.
  assign pat_we    = (state_r == ST_PPOW);
  assign pat_raddr = idx_r[IDX_W-1:0];

  rhpm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (plen_r[IDX_W-1:0]),
    .wdata (char_r),
    .raddr (pat_raddr),
    .rdata (pat_rd)
  );

  // Window store: appended while filling, oldest byte replaced once full.
  assign win_we    = (state_r == ST_TFILL) || ((state_r == ST_TRTH_W) && mr_rsp.done);
  assign win_waddr = (state_r == ST_TFILL) ? fill_r[IDX_W-1:0] : head_r;
  assign win_raddr = (state_r == ST_TLEAD) ? head_r : cmp_addr;

  rhpm_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_PATTERN)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (char_r),
    .raddr (win_raddr),
    .rdata (win_rd)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= PRIME_RST;
      base_r  <= BASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRIME: prime_r <= cfg_wdata[WORD_W-1:0];
        CFG_BASE:  base_r  <= cfg_wdata[BASE_W-1:0];
        default:   ;
      endcase
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      plen_r  <= '0;
      ph_r    <= '0;
      pow_r   <= WORD_W'(1);
      fill_r  <= '0;
      th_r    <= '0;
      head_r  <= '0;
      tpos_r  <= '0;
    end else begin
      case (state_r)
        // Take an item and apply its restart and window clearing.
        ST_IDLE: begin
          if (in_accept) begin
            char_r     <= in_ch.char_value;
            res_hit_r  <= 1'b0;
            res_full_r <= 1'b0;
            if (in_ch.op == OP_PATTERN) begin
              if (in_ch.restart) begin
                plen_r <= '0;
                ph_r   <= '0;
                pow_r  <= WORD_W'(1);
              end
              fill_r <= '0;
              th_r   <= '0;
              head_r <= '0;
              state_r <= (eff_len < LEN_W'(MAX_PATTERN)) ? ST_PPOW : ST_DONE;
            end else begin
              if (in_ch.restart) begin
                fill_r <= '0;
                th_r   <= '0;
                head_r <= '0;
              end
              pos_r  <= eff_tpos;
              tpos_r <= eff_tpos + POS_W'(1);
              if (plen_r == '0) begin
                state_r <= ST_DONE;
              end else if (eff_fill < plen_r) begin
                state_r <= ST_TFILL;
              end else begin
                state_r <= ST_TLEAD;
              end
            end
          end
        end

        // Pattern byte: advance the leading power, then the pattern hash.
        ST_PPOW: begin
          state_r <= (plen_r != '0) ? ST_PPOW_W : ST_PHASH;
        end
        ST_PPOW_W: begin
          if (mr_rsp.done) begin
            pow_r   <= mr_rsp.result;
            state_r <= ST_PHASH;
          end
        end
        ST_PHASH: begin
          state_r <= ST_PHASH_W;
        end
        ST_PHASH_W: begin
          if (mr_rsp.done) begin
            ph_r    <= mr_rsp.result;
            plen_r  <= plen_r + LEN_W'(1);
            state_r <= ST_DONE;
          end
        end

        // Text byte while the window fills.
        ST_TFILL: begin
          fill_r  <= fill_r + LEN_W'(1);
          state_r <= ST_TFILL_W;
        end
        ST_TFILL_W: begin
          if (mr_rsp.done) begin
            th_r <= mr_rsp.result;
            if (fill_r == plen_r) begin
              res_full_r <= 1'b1;
              state_r    <= ST_RPH;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end

        // Text byte with a full window: drop the oldest byte, add the new one.
        ST_TLEAD: begin
          state_r <= ST_TLEAD_GO;
        end
        ST_TLEAD_GO: begin
          state_r <= ST_TLEAD_W;
        end
        ST_TLEAD_W: begin
          if (mr_rsp.done) begin
            lead_r  <= mr_rsp.result;
            state_r <= ST_TRTH;
          end
        end
        ST_TRTH: begin
          state_r <= ST_TRTH_W;
        end
        ST_TRTH_W: begin
          if (mr_rsp.done) begin
            th_r    <= sub_res;
            head_r  <= head_inc;
            state_r <= ST_TMAC;
          end
        end
        ST_TMAC: begin
          state_r <= ST_TMAC_W;
        end
        ST_TMAC_W: begin
          if (mr_rsp.done) begin
            th_r       <= mr_rsp.result;
            res_full_r <= 1'b1;
            state_r    <= ST_RPH;
          end
        end

        // Compare hashes under the current modulus.
        ST_RPH: begin
          state_r <= ST_RPH_W;
        end
        ST_RPH_W: begin
          if (mr_rsp.done) begin
            if (mr_rsp.result == th_r) begin
              idx_r   <= '0;
              chk_r   <= 1'b0;
              mism_r  <= 1'b0;
              state_r <= ST_CMP;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end

        // Confirm byte by byte; read data arrives in the cycle after its address.
        ST_CMP: begin
          if (idx_r < plen_r) begin
            idx_r <= idx_r + LEN_W'(1);
            chk_r <= 1'b1;
          end else begin
            chk_r <= 1'b0;
          end
          if (chk_r && (pat_rd != win_rd)) begin
            mism_r <= 1'b1;
          end
          if ((idx_r == plen_r) && !chk_r) begin
            res_hit_r <= !mism_r;
            state_r   <= ST_DONE;
          end
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (out_free) begin
            out_match_r <= res_hit_r;
            out_start_r <= res_hit_r ? (pos_r - POS_W'(plen_r) + POS_W'(1)) : '0;
            out_full_r  <= res_full_r;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
